// ----- rtl/tile_row_sprite_pixel_mixer_defines.svh -----
// Assertion macros for the tile row sprite pixel mixer.
`ifndef TILE_ROW_SPRITE_PIXEL_MIXER_DEFINES_SVH
`define TILE_ROW_SPRITE_PIXEL_MIXER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TRSPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tile row mixer assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define TRSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tile row mixer assertion failed");

`endif

// ----- rtl/trspm_pkg.sv -----
// Package for the tile row sprite pixel mixer: types, register codes, reset values.
`timescale 1ns / 1ps
`default_nettype none
package trspm_pkg;

  localparam int MAX_SPRITES_DEF = 3;
  localparam int PIX_PER_ROW     = 8;
  localparam int PIX_IDX_W       = 3;
  localparam int POS_W           = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;
  localparam int SPRITE_X_BIAS   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FINE_SCROLL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_PALETTE0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_PALETTE1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ENABLE   = 3'd5;

  localparam logic       REQ_LOAD = 1'b0;
  localparam logic       REQ_PUSH = 1'b1;

  localparam logic [2:0] RST_FINE_SCROLL  = 3'd0;
  localparam logic [7:0] RST_BG_PALETTE   = 8'd252;
  localparam logic [7:0] RST_OBJ_PALETTE0 = 8'd255;
  localparam logic [7:0] RST_OBJ_PALETTE1 = 8'd255;
  localparam logic       RST_BG_ENABLE    = 1'b1;
  localparam logic       RST_OBJ_ENABLE   = 1'b0;

  typedef struct packed {
    logic [7:0] x;
    logic       flip;
    logic       behind;
    logic       pal;
    logic [7:0] plo;
    logic [7:0] phi;
  } slot_t;

  function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] idx);
    logic [1:0] s;
    unique case (idx)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tile_row_sprite_pixel_mixer.sv -----
// A load word writes one sprite slot and gives no result. A push word (one background
// tile row of eight pixels) is mixed one pixel per cycle while the output is not stalled:
// each step one pixel goes through the background, sprite priority and palette logic,
// and a pixel that gives a result is written into the output register. Pixels whose line
// position is below fine_scroll still step the pixel loop but give no result. The next
// word is taken in the cycle the last pixel of the current push is mixed; output stalls
// hold the pixel loop.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_row_sprite_pixel_mixer_defines.svh"
module tile_row_sprite_pixel_mixer #(
  parameter int MAX_SPRITES = trspm_pkg::MAX_SPRITES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [trspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trspm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_req_type,
  input  wire logic [1:0]                       in_slot,
  input  wire logic [7:0]                       in_sprite_x,
  input  wire logic                             in_x_flip,
  input  wire logic                             in_behind_background,
  input  wire logic                             in_palette_select,
  input  wire logic [7:0]                       in_pattern_low,
  input  wire logic [7:0]                       in_pattern_high,
  input  wire logic [1:0]                       in_sprite_count,
  input  wire logic                             in_line_start,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_shade,
  output logic                                  out_last_of_tile
);

  localparam int PIX_IDX_W = trspm_pkg::PIX_IDX_W;
  localparam int POS_W     = trspm_pkg::POS_W;
  localparam logic [PIX_IDX_W-1:0] LAST_PIX = PIX_IDX_W'(trspm_pkg::PIX_PER_ROW - 1);

  // configuration
  logic [2:0] fine_scroll_r;
  logic [7:0] bg_palette_r;
  logic [7:0] obj_palette0_r;
  logic [7:0] obj_palette1_r;
  logic       bg_enable_r;
  logic       obj_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_scroll_r  <= trspm_pkg::RST_FINE_SCROLL;
      bg_palette_r   <= trspm_pkg::RST_BG_PALETTE;
      obj_palette0_r <= trspm_pkg::RST_OBJ_PALETTE0;
      obj_palette1_r <= trspm_pkg::RST_OBJ_PALETTE1;
      bg_enable_r    <= trspm_pkg::RST_BG_ENABLE;
      obj_enable_r   <= trspm_pkg::RST_OBJ_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trspm_pkg::CFG_FINE_SCROLL:  fine_scroll_r  <= cfg_wdata[2:0];
        trspm_pkg::CFG_BG_PALETTE:   bg_palette_r   <= cfg_wdata;
        trspm_pkg::CFG_OBJ_PALETTE0: obj_palette0_r <= cfg_wdata;
        trspm_pkg::CFG_OBJ_PALETTE1: obj_palette1_r <= cfg_wdata;
        trspm_pkg::CFG_BG_ENABLE:    bg_enable_r    <= cfg_wdata[0];
        trspm_pkg::CFG_OBJ_ENABLE:   obj_enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pixel loop state
  logic                 busy_r;
  logic [PIX_IDX_W-1:0] idx_r;
  logic [POS_W-1:0]     pos_r;
  logic [7:0]           bg_lo_r;
  logic [7:0]           bg_hi_r;
  logic [1:0]           count_r;
  trspm_pkg::slot_t     slots_r [MAX_SPRITES];

  logic       out_valid_r;
  logic [1:0] out_shade_r;
  logic       out_last_r;

  logic       out_free;
  logic       emit;
  logic       adv;
  logic       in_acc;
  logic       push_acc;
  logic       later_emit;
  logic [1:0] count_sat;
  logic [1:0] bg_idx;
  logic [1:0] pix_shade;
  logic       spr_hit;
  logic [1:0] spr_shade;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = pos_r >= POS_W'(fine_scroll_r);
  assign adv      = busy_r && (!emit || out_free);
  assign in_stall = busy_r && !(adv && idx_r == LAST_PIX);
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && in_req_type == trspm_pkg::REQ_PUSH;

  assign count_sat = (int'(in_sprite_count) > MAX_SPRITES) ? 2'(MAX_SPRITES) : in_sprite_count;

  // any later pixel of this row still on screen
  always_comb begin
    logic [PIX_IDX_W:0] j;
    logic [POS_W-1:0]   p;
    later_emit = 1'b0;
    for (int k = 1; k < trspm_pkg::PIX_PER_ROW; k++) begin
      j = {1'b0, idx_r} + (PIX_IDX_W + 1)'(k);
      p = pos_r + POS_W'(k);
      if (!j[PIX_IDX_W] && p >= POS_W'(fine_scroll_r)) later_emit = 1'b1;
    end
  end

  always_comb begin
    logic [PIX_IDX_W-1:0] b;
    b = ~idx_r;
    bg_idx = bg_enable_r ? {bg_hi_r[b], bg_lo_r[b]} : 2'd0;
  end

  // sprite overlay, lowest slot wins
  always_comb begin
    logic signed [9:0] off;
    logic [2:0]        sb;
    logic [1:0]        sidx;
    spr_hit   = 1'b0;
    spr_shade = 2'd0;
    for (int k = 0; k < MAX_SPRITES; k++) begin
      off  = $signed({2'b00, pos_r}) + $signed(10'(trspm_pkg::SPRITE_X_BIAS))
             - $signed({2'b00, slots_r[k].x}) - $signed({7'd0, fine_scroll_r});
      sb   = slots_r[k].flip ? off[2:0] : ~off[2:0];
      sidx = {slots_r[k].phi[sb], slots_r[k].plo[sb]};
      if (!spr_hit && k < int'(count_r) && off[9:3] == 7'd0 && sidx != 2'd0
          && (!slots_r[k].behind || bg_idx == 2'd0)) begin
        spr_hit   = 1'b1;
        spr_shade = trspm_pkg::pal_shade(slots_r[k].pal ? obj_palette1_r : obj_palette0_r,
                                         sidx);
      end
    end
  end

  assign pix_shade = (obj_enable_r && spr_hit) ? spr_shade
                                               : trspm_pkg::pal_shade(bg_palette_r, bg_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (adv) begin
        idx_r <= idx_r + PIX_IDX_W'(1);
        pos_r <= pos_r + POS_W'(1);
        if (idx_r == LAST_PIX) busy_r <= 1'b0;
      end
      if (push_acc) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        if (in_line_start) pos_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      bg_lo_r <= in_pattern_low;
      bg_hi_r <= in_pattern_high;
      count_r <= count_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == trspm_pkg::REQ_LOAD) begin
      for (int k = 0; k < MAX_SPRITES; k++) begin
        if (int'(in_slot) == k) begin
          slots_r[k] <= '{x: in_sprite_x, flip: in_x_flip, behind: in_behind_background,
                          pal: in_palette_select, plo: in_pattern_low,
                          phi: in_pattern_high};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_shade_r <= pix_shade;
      out_last_r  <= !later_emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shade        = out_shade_r;
  assign out_last_of_tile = out_last_r;

  `TRSPM_ASSERT_NEXT(a_push_starts, clk, rst_n, push_acc, busy_r && idx_r == '0)
  `TRSPM_ASSERT_NEXT(a_idx_steps, clk, rst_n, adv && idx_r != LAST_PIX, busy_r && idx_r == $past(idx_r) + PIX_IDX_W'(1))
  `TRSPM_ASSERT_NEXT(a_row_ends, clk, rst_n, adv && idx_r == LAST_PIX && !push_acc, !busy_r)
  `TRSPM_ASSERT_NEXT(a_pixel_lands, clk, rst_n, adv && emit, out_valid_r)
  `TRSPM_ASSERT_NOW(a_idle_takes, clk, rst_n, !busy_r, !in_stall)

endmodule
`default_nettype wire
